/* rtl/lightmap_overbright_scale_assert.svh */
// Assertion macros for the overbright scaling block.
// Used by the top level; expects a clock named i_clk and a reset named i_rst_n.
`ifndef LIGHTMAP_OVERBRIGHT_SCALE_ASSERT_SVH
`define LIGHTMAP_OVERBRIGHT_SCALE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LMOS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lightmap_overbright_scale: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LMOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lightmap_overbright_scale: next-cycle check failed");

`endif

/* rtl/lmos_pkg.sv */
// Shared constants and types of the overbright scaling block.
// No dependencies; used by the interfaces and every module.
`timescale 1ns / 1ps

package lmos_pkg;

    localparam int ChanW        = 8;
    localparam int NumChan      = 3;
    localparam int GainW        = 12;
    localparam int GainFracBits = 8;
    localparam int DivSteps     = ChanW;
    // Wide enough for both the channel product and the full-scale limit.
    localparam int ProdW = (GainW > GainFracBits) ? ChanW + GainW : ChanW + GainFracBits;
    localparam int Ch255W = 2 * ChanW;

    localparam logic [GainW-1:0] GainReset = GainW'(640);
    localparam logic [ChanW-1:0] FullScale = {ChanW{1'b1}};
    localparam logic [ProdW-1:0] PlainLimit = ProdW'(FullScale) << GainFracBits;

    typedef logic [NumChan-1:0][ChanW-1:0] t_chans;

    // Word carried along the division chain.
    typedef struct packed {
        logic               limited;
        logic [ChanW-1:0]   peak;
        t_chans             plain;
        t_chans             rem;
        t_chans             quo;
    } t_cell;

endpackage

/* rtl/lmos_if.sv */
// Handshake interfaces for pixel input, pixel output and the gain write port.
// Depends on lmos_pkg.
`timescale 1ns / 1ps

interface lmos_pix_in_if;
    import lmos_pkg::*;
    logic             valid;
    logic             ready;
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    modport source (output valid, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface lmos_pix_out_if;
    import lmos_pkg::*;
    logic             valid;
    logic             ready;
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic             was_limited;
    modport source (output valid, red_out, green_out, blue_out, was_limited, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, was_limited, output ready);
endinterface

interface lmos_cfg_if;
    import lmos_pkg::*;
    logic             valid;
    logic             ready;
    logic [GainW-1:0] gain;
    modport source (output valid, gain, input ready);
    modport sink   (input valid, gain, output ready);
endinterface

/* rtl/lmos_front.sv */
// Front stage: channel products with the gain, peak channel and the x255 dividends.
// Depends on lmos_pkg; feeds the first division cell.
`timescale 1ns / 1ps

module lmos_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  lmos_pkg::t_chans      i_chans,
    input  logic [lmos_pkg::GainW-1:0] i_gain,
    output logic                  o_ready,
    input  logic                  i_ready,
    output logic                  o_valid,
    output lmos_pkg::t_cell       o_cell
);
    import lmos_pkg::*;

    logic                              r_valid;
    logic [ChanW-1:0]                  r_peak;
    logic [NumChan-1:0][ProdW-1:0]     r_prod;
    logic [NumChan-1:0][Ch255W-1:0]    r_ch255;
    logic [ChanW-1:0]                  n_peak;
    logic [NumChan-1:0][ProdW-1:0]     n_prod;
    logic [NumChan-1:0][Ch255W-1:0]    n_ch255;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_comb begin
        n_peak = i_chans[0];
        for (int c = 1; c < NumChan; c++) begin
            if (i_chans[c] > n_peak) begin
                n_peak = i_chans[c];
            end
        end
        for (int c = 0; c < NumChan; c++) begin
            n_prod[c]  = ProdW'(i_chans[c]) * ProdW'(i_gain);
            // ch * 255 as (ch << 8) - ch.
            n_ch255[c] = {i_chans[c], {ChanW{1'b0}}} - Ch255W'(i_chans[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_peak  <= n_peak;
            r_prod  <= n_prod;
            r_ch255 <= n_ch255;
        end
    end

    // The gain is nonnegative, so the peak channel gives the largest product.
    always_comb begin
        o_cell.limited = 1'b0;
        o_cell.peak    = r_peak;
        for (int c = 0; c < NumChan; c++) begin
            if (r_prod[c] > PlainLimit) begin
                o_cell.limited = 1'b1;
            end
            o_cell.plain[c] = ChanW'(r_prod[c] >> GainFracBits);
            o_cell.rem[c]   = r_ch255[c][Ch255W-1:ChanW];
            o_cell.quo[c]   = r_ch255[c][ChanW-1:0];
        end
    end

endmodule

/* rtl/lmos_div_cell.sv */
// One restoring-division cell: produces one quotient bit per channel and passes on.
// Depends on lmos_pkg; chained DivSteps times by the top level.
`timescale 1ns / 1ps

module lmos_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lmos_pkg::t_cell i_cell,
    output logic            o_ready,
    input  logic            i_ready,
    output logic            o_valid,
    output lmos_pkg::t_cell o_cell
);
    import lmos_pkg::*;

    logic  r_valid;
    t_cell r_cell;
    t_cell n_cell;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cell  = r_cell;

    // The quo field starts as the low dividend bits; each step shifts one of them
    // into the remainder and one quotient bit in at the bottom.
    always_comb begin
        logic [ChanW:0] trial;
        logic           qbit;
        n_cell = i_cell;
        for (int c = 0; c < NumChan; c++) begin
            trial = {i_cell.rem[c], i_cell.quo[c][ChanW-1]};
            qbit  = (trial >= {1'b0, i_cell.peak});
            if (qbit) begin
                n_cell.rem[c] = ChanW'(trial - {1'b0, i_cell.peak});
            end else begin
                n_cell.rem[c] = ChanW'(trial);
            end
            n_cell.quo[c] = {i_cell.quo[c][ChanW-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_cell <= n_cell;
        end
    end

endmodule

/* rtl/lightmap_overbright_scale.sv */
// Top level of the overbright scaling block: gain register, front stage,
// division chain and output register. Depends on lmos_pkg, the interfaces,
// lmos_front, lmos_div_cell and the assertion header.
//
// Usage:
//   i_pix carries one RGB word per transfer; o_pix returns one word per input
//   word, in order, with was_limited set when the pixel was renormalized.
//   i_cfg writes the 12-bit gain (8 fraction bits); it is always ready and
//   should only be written while no pixel is in flight.
//   A word accepted on i_pix passes one front stage with the three gain
//   multipliers, eight division cells (one quotient bit each) and the output
//   register. Throughput is one word per cycle unless o_pix stalls.
//   Each stage holds its word when its successor is full and stalled, so a
//   stalled receiver fills the chain up before i_pix.ready falls; bubbles are
//   squeezed out while the output waits.
//   Reset empties the chain and sets the gain to 2.5.
`timescale 1ns / 1ps
`include "lightmap_overbright_scale_assert.svh"

module lightmap_overbright_scale (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lmos_pix_in_if.sink    i_pix,
    lmos_cfg_if.sink       i_cfg,
    lmos_pix_out_if.source o_pix
);
    import lmos_pkg::*;

    logic [GainW-1:0]  r_gain;
    t_chans            in_chans;
    logic [DivSteps:0] stg_valid;
    logic [DivSteps:0] stg_ready;
    t_cell             stg_cell [DivSteps+1];
    logic              out_ready;
    logic              r_out_valid;
    logic              r_out_limited;
    t_chans            r_out_chans;
    t_chans            n_out_chans;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GainReset;
        end else if (i_cfg.valid) begin
            r_gain <= i_cfg.gain;
        end
    end

    assign in_chans[0] = i_pix.red_in;
    assign in_chans[1] = i_pix.green_in;
    assign in_chans[2] = i_pix.blue_in;

    lmos_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .i_chans (in_chans),
        .i_gain  (r_gain),
        .o_ready (i_pix.ready),
        .i_ready (stg_ready[0]),
        .o_valid (stg_valid[0]),
        .o_cell  (stg_cell[0])
    );

    for (genvar k = 0; k < DivSteps; k++) begin : g_cell
        lmos_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .i_cell  (stg_cell[k]),
            .o_ready (stg_ready[k]),
            .i_ready (stg_ready[k+1]),
            .o_valid (stg_valid[k+1]),
            .o_cell  (stg_cell[k+1])
        );
    end

    assign out_ready            = !r_out_valid || o_pix.ready;
    assign stg_ready[DivSteps]  = out_ready;

    always_comb begin
        for (int c = 0; c < NumChan; c++) begin
            n_out_chans[c] = stg_cell[DivSteps].limited ? stg_cell[DivSteps].quo[c]
                                                         : stg_cell[DivSteps].plain[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= stg_valid[DivSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out_chans   <= n_out_chans;
            r_out_limited <= stg_cell[DivSteps].limited;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.red_out     = r_out_chans[0];
    assign o_pix.green_out   = r_out_chans[1];
    assign o_pix.blue_out    = r_out_chans[2];
    assign o_pix.was_limited = r_out_limited;

    // A renormalized word always has its peak channel at full scale.
    `LMOS_ASSERT_NOW(a_limited_peak, o_pix.valid && o_pix.was_limited,
        o_pix.red_out == FullScale || o_pix.green_out == FullScale || o_pix.blue_out == FullScale)
    // Input back-pressure only ever comes from a full chain behind a stalled output.
    `LMOS_ASSERT_NOW(a_stall_source, !i_pix.ready,
        o_pix.valid && !o_pix.ready && (&stg_valid))
    // A gain write lands in the register on the next cycle.
    `LMOS_ASSERT_NEXT(a_gain_write, i_cfg.valid && i_cfg.ready, r_gain == $past(i_cfg.gain))

endmodule
